>>> hdl/record_ring_fifo_defines.svh
// ----------------------------------------------------------------------------
// record_ring_fifo_defines
// assertion macros used by the record ring fifo module
// ----------------------------------------------------------------------------
`ifndef RECORD_RING_FIFO_DEFINES_SVH
`define RECORD_RING_FIFO_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record ring fifo check failed");

// next-cycle implication, checked outside reset
`define RRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record ring fifo check failed");

`endif

>>> hdl/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// types, codes and helpers of the record ring fifo
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam int CNT_W      = 16;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int REC_LEN_W  = 8;
    localparam int ST_W       = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam int DEPTH_DEF      = 16;
    localparam int SLOT_BYTES_DEF = 8;

    localparam logic [3:0]  SLOT_LIMIT_RST = 4'd8;
    localparam logic [4:0]  RING_DEPTH_RST = 5'd16;
    localparam logic [15:0] MAX_INDEX_RST  = 16'hFFFF;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RING_DEPTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_INDEX  = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_LONG     = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CAPACITY = 3'd5
    } t_status;

    typedef struct packed {
        logic [3:0]  slot_limit;
        logic [4:0]  ring_depth;
        logic [15:0] max_index;
    } t_cfg;

    // mask covering the low n bytes of a word
    function automatic logic [DATA_W-1:0] rrf_byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < n) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> hdl/rrf_if.sv
// ----------------------------------------------------------------------------
// rrf_if
// valid/ready channels of the record ring fifo
// ----------------------------------------------------------------------------
interface rrf_in_if import rrf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [DATA_W-1:0]    record_data;
    logic [REC_LEN_W-1:0] record_length;
    logic [REC_LEN_W-1:0] pop_capacity;

    modport source (output valid, func, record_data, record_length, pop_capacity,
                    input ready);
    modport sink   (input valid, func, record_data, record_length, pop_capacity,
                    output ready);
endinterface

interface rrf_out_if import rrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  read_length;

    modport source (output valid, status, read_data, read_length, input ready);
    modport sink   (input valid, status, read_data, read_length, output ready);
endinterface

>>> hdl/record_ring_fifo.sv
// ----------------------------------------------------------------------------
// record_ring_fifo
// ring of fixed-size slots holding variable-length records with their length
// ----------------------------------------------------------------------------
// One word goes in per push or pop and one status word comes out for each,
// in order. A word is taken into an input register, decided against the
// ring state once the result register is free or draining and lands in
// the result register, so a new word can be taken every cycle as long as
// the result side keeps draining. The pop path never waits on the slot
// memory: the record at the read pointer is prefetched into a head register
// every cycle, with a bypass when a push writes that very slot, so the single
// write port and single registered read port of the slot memory set the rate
// at one word per cycle. Configuration is by apb at byte address 4*index
// (slot_limit, ring_depth, max_index) and is to be changed only while idle.
// Slot contents have no reset; the ring starts empty after reset.
module record_ring_fifo import rrf_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrf_in_if.sink                i_in,
    rrf_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "record_ring_fifo_defines.svh"

    // slot index and payload widths
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = 8 * SLOT_BYTES;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [LEN_W-1:0] SLOT_BYTES_C = LEN_W'(SLOT_BYTES);

    t_cfg cfg;

    rrf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic                 r_in_valid;
    logic                 r_in_func;
    logic [DW-1:0]        r_in_data;
    logic [REC_LEN_W-1:0] r_in_len;
    logic [REC_LEN_W-1:0] r_in_cap;

    // ring state
    logic [CNT_W-1:0] r_wr_count, n_wr_count;
    logic [CNT_W-1:0] r_rd_count, n_rd_count;
    logic [SW-1:0]    r_wr_slot,  n_wr_slot;
    logic [SW-1:0]    r_rd_slot,  n_rd_slot;

    // slot memory: length on top, payload below
    logic [LEN_W+DW-1:0] mem [DEPTH];
    logic [LEN_W-1:0]    r_head_len;
    logic [DW-1:0]       r_head_data;

    // result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic [LEN_W-1:0]  r_out_len;

    // decision path
    logic              proc;
    logic              wr_en;
    logic [SW-1:0]     wr_addr;
    logic [DW-1:0]     wr_data;
    t_status           status;
    logic [DATA_W-1:0] rdata;
    logic [LEN_W-1:0]  rlen;
    logic [CNT_W-1:0]  eff_depth;
    logic [LEN_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  count;
    logic              ring_empty;
    logic [CNT_W-1:0]  wc_base;
    logic [SW-1:0]     ws_base;
    logic [DATA_W-1:0] push_mask;
    logic [DATA_W-1:0] pop_mask;

    // the input register frees up whenever its word moves to the result side
    assign proc       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    always_comb begin
        // depth of zero acts as one, beyond the memory acts as the memory
        if (cfg.ring_depth == '0) begin
            eff_depth = CNT_W'(1);
        end else if (CNT_W'(cfg.ring_depth) > DEPTH_C) begin
            eff_depth = DEPTH_C;
        end else begin
            eff_depth = CNT_W'(cfg.ring_depth);
        end
        eff_limit = (cfg.slot_limit < SLOT_BYTES_C) ? cfg.slot_limit : SLOT_BYTES_C;

        count      = r_wr_count - r_rd_count;
        ring_empty = (count == '0);
        wc_base    = ring_empty ? '0 : r_wr_count;
        ws_base    = ring_empty ? '0 : r_wr_slot;
        push_mask  = rrf_byte_mask(r_in_len[LEN_W-1:0]);
        pop_mask   = rrf_byte_mask(r_head_len);

        n_wr_count = r_wr_count;
        n_rd_count = r_rd_count;
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        wr_en      = 1'b0;
        wr_addr    = ws_base;
        wr_data    = r_in_data & push_mask[DW-1:0];
        status     = ST_OK;
        rdata      = '0;
        rlen       = '0;

        if (r_in_func == FUNC_PUSH) begin
            if (r_in_len > REC_LEN_W'(eff_limit)) begin
                status = ST_LONG;
            end else begin
                // drained ring restarts from zero
                if (proc && ring_empty) begin
                    n_wr_count = '0;
                    n_rd_count = '0;
                    n_wr_slot  = '0;
                    n_rd_slot  = '0;
                end
                if (wc_base == cfg.max_index) begin
                    status = ST_OVERFLOW;
                end else if (count < eff_depth) begin
                    wr_en = proc;
                    if (proc) begin
                        n_wr_count = wc_base + 1'b1;
                        n_wr_slot  = ((CNT_W'(ws_base) + 1'b1) >= eff_depth) ?
                                     '0 : ws_base + 1'b1;
                    end
                end else begin
                    status = ST_FULL;
                end
            end
        end else begin
            if (r_wr_count <= r_rd_count) begin
                status = ST_EMPTY;
            end else if (r_in_cap < REC_LEN_W'(r_head_len)) begin
                status = ST_CAPACITY;
            end else begin
                rdata = DATA_W'(r_head_data & pop_mask[DW-1:0]);
                rlen  = r_head_len;
                if (proc) begin
                    n_rd_count = r_rd_count + 1'b1;
                    n_rd_slot  = ((CNT_W'(r_rd_slot) + 1'b1) >= eff_depth) ?
                                 '0 : r_rd_slot + 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_count  <= '0;
            r_rd_count  <= '0;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_wr_count <= n_wr_count;
            r_rd_count <= n_rd_count;
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_func <= i_in.func;
            r_in_data <= i_in.record_data[DW-1:0];
            r_in_len  <= i_in.record_length;
            r_in_cap  <= i_in.pop_capacity;
        end
        if (proc) begin
            r_out_status <= status;
            r_out_data   <= rdata;
            r_out_len    <= rlen;
        end
    end

    // slot memory with head prefetch at the next read pointer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {r_in_len[LEN_W-1:0], wr_data};
        end
        if (wr_en && (wr_addr == n_rd_slot)) begin
            r_head_len  <= r_in_len[LEN_W-1:0];
            r_head_data <= wr_data;
        end else begin
            {r_head_len, r_head_data} <= mem[n_rd_slot];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.read_data   = r_out_data;
    assign o_out.read_length = r_out_len;

    // a failed result never carries record bytes
    `RRF_ASSERT_IMP(a_fail_clean, i_clk, i_rst_n, r_out_valid && r_out_status != ST_OK, r_out_data == '0 && r_out_len == '0)
    // no result appears without a word in the input register
    `RRF_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, !r_out_valid && !r_in_valid, !r_out_valid)
    // input side stalls only behind a held word
    `RRF_ASSERT_IMP(a_stall_held, i_clk, i_rst_n, !i_in.ready, r_in_valid && r_out_valid)
    // state moves only when a word is decided
    `RRF_ASSERT_NXT(a_state_quiet, i_clk, i_rst_n, !proc, $stable(r_wr_count) && $stable(r_rd_count))

endmodule

>>> hdl/rrf_regs.sv
// ----------------------------------------------------------------------------
// rrf_regs
// apb configuration registers of the record ring fifo
// ----------------------------------------------------------------------------
module rrf_regs import rrf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_limit <= SLOT_LIMIT_RST;
            r_cfg.ring_depth <= RING_DEPTH_RST;
            r_cfg.max_index  <= MAX_INDEX_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLOT_LIMIT: r_cfg.slot_limit <= pwdata[3:0];
                REG_RING_DEPTH: r_cfg.ring_depth <= pwdata[4:0];
                REG_MAX_INDEX:  r_cfg.max_index  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLOT_LIMIT: prdata = APB_DATA_W'(r_cfg.slot_limit);
            REG_RING_DEPTH: prdata = APB_DATA_W'(r_cfg.ring_depth);
            REG_MAX_INDEX:  prdata = APB_DATA_W'(r_cfg.max_index);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
